/* hw/rtl/ecp_pkg.sv */
// ----------------------------------------------------------------------------
// ecp_pkg: shared types and helpers for the equality constraint projection
// Item layouts for both channels, the queue entry, default sizes and
// fixed point helpers.
// ----------------------------------------------------------------------------
package ecp_pkg;

    localparam int MAX_DIMS_DEF        = 16;
    localparam int MAX_CONSTRAINTS_DEF = 4;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int QUEUE_DEPTH         = 4;

    // input commands
    localparam logic [1:0] CMD_LOAD_MAT = 2'd0;
    localparam logic [1:0] CMD_LOAD_TGT = 2'd1;
    localparam logic [1:0] CMD_ELEMENT  = 2'd2;

    // configuration register indexes
    localparam logic REG_DIMS = 1'b0;
    localparam logic REG_CONS = 1'b1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] projected;
        logic               end_of_vector;
        logic               singular;
    } out_item_t;

    typedef enum logic [1:0] {
        K_MAT = 2'd0,
        K_TGT = 2'd1,
        K_VEC = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               wr;
        logic               last;
        logic [1:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } q_item_t;

    // sign extend to the accumulator width
    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // clamp a wide value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

/* hw/rtl/ecp_queue.sv */
// ----------------------------------------------------------------------------
// ecp_queue: short queue between front and back
// Register based FIFO of classified items.
// ----------------------------------------------------------------------------
module ecp_queue
    import ecp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output logic    valid,
    output q_item_t head
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    q_item_t       mem_reg [0:QUEUE_DEPTH-1];
    logic [PW:0]   wr_ptr_reg;
    logic [PW:0]   rd_ptr_reg;

    assign valid = (wr_ptr_reg != rd_ptr_reg);
    assign full  = (wr_ptr_reg[PW] != rd_ptr_reg[PW]) &&
                   (wr_ptr_reg[PW-1:0] == rd_ptr_reg[PW-1:0]);
    assign head  = mem_reg[rd_ptr_reg[PW-1:0]];

    // store pushed item
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg[PW-1:0]] <= push_item;
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

endmodule

/* hw/rtl/ecp_front.sv */
// ----------------------------------------------------------------------------
// ecp_front: input side of the projection block
// Accepts items, drops those that do nothing and queues the rest by kind.
// ----------------------------------------------------------------------------
module ecp_front
    import ecp_pkg::*;
#(
    parameter int MAX_DIMS        = MAX_DIMS_DEF,
    parameter int MAX_CONSTRAINTS = MAX_CONSTRAINTS_DEF
)
(
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     q_full,
    output logic     q_push,
    output q_item_t  q_item
);

    logic row_ok;
    logic col_ok;
    logic keep;

    assign row_ok = int'(in_data.row) < MAX_CONSTRAINTS;
    assign col_ok = int'(in_data.col) < MAX_DIMS;

    // classify the item
    always_comb
    begin
        q_item.row   = in_data.row;
        q_item.col   = in_data.col;
        q_item.value = in_data.value;
        q_item.last  = 1'b0;
        q_item.wr    = 1'b0;
        q_item.kind  = K_VEC;
        keep         = 1'b0;
        case (in_data.cmd)
            CMD_LOAD_MAT:
            begin
                q_item.kind = K_MAT;
                q_item.wr   = 1'b1;
                keep        = row_ok && col_ok;
            end
            CMD_LOAD_TGT:
            begin
                q_item.kind = K_TGT;
                q_item.wr   = 1'b1;
                keep        = row_ok;
            end
            CMD_ELEMENT:
            begin
                q_item.kind = K_VEC;
                q_item.wr   = col_ok;
                q_item.last = in_data.last;
                keep        = col_ok || in_data.last;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && keep;

endmodule

/* hw/rtl/ecp_div.sv */
// ----------------------------------------------------------------------------
// ecp_div: fixed point divider
// Restoring division of a * 2^F by b, one quotient bit per cycle,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module ecp_div
    import ecp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic               done,
    output logic signed [31:0] q
);

    localparam int NUMW = 32 + FRAC_BITS;
    localparam int CNTW = $clog2(NUMW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [NUMW-1:0]   num_reg;
    logic [32:0]       rem_reg;
    logic [31:0]       den_reg;
    logic              neg_reg;
    logic signed [31:0] q_reg;

    logic [31:0]       abs_a;
    logic [31:0]       abs_b;
    logic [32:0]       rem_sh;
    logic              ge;
    logic [32:0]       rem_n;
    logic [NUMW-1:0]   num_n;
    logic signed [31:0] q_sat;

    assign abs_a = a[31] ? 32'(-a) : a;
    assign abs_b = b[31] ? 32'(-b) : b;

    // one restoring step
    assign rem_sh = {rem_reg[31:0], num_reg[NUMW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign rem_n  = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    assign num_n  = {num_reg[NUMW-2:0], ge};

    // apply sign and saturate the magnitude
    always_comb
    begin
        if (!neg_reg && num_n > NUMW'(64'h7FFF_FFFF))
            q_sat = 32'sh7FFF_FFFF;
        else if (neg_reg && num_n > NUMW'(64'h8000_0000))
            q_sat = 32'sh8000_0000;
        else if (neg_reg)
            q_sat = 32'(-num_n);
        else
            q_sat = num_n[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            neg_reg  <= 1'b0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NUMW - 1);
                num_reg  <= {abs_a, {FRAC_BITS{1'b0}}};
                rem_reg  <= '0;
                den_reg  <= abs_b;
                neg_reg  <= a[31] ^ b[31];
            end
            else if (busy_reg)
            begin
                num_reg <= num_n;
                rem_reg <= rem_n;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    q_reg    <= q_sat;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

/* hw/rtl/ecp_back.sv */
// ----------------------------------------------------------------------------
// ecp_back: execution side of the projection block
// Stores loads and elements, then on a last element forms E E^T and
// E x - c, eliminates with partial pivoting, back substitutes and emits
// the projected vector (input vector on a zero pivot) via an output register.
// ----------------------------------------------------------------------------
module ecp_back
    import ecp_pkg::*;
#(
    parameter int MAX_DIMS        = MAX_DIMS_DEF,
    parameter int MAX_CONSTRAINTS = MAX_CONSTRAINTS_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [$clog2(MAX_DIMS+1)-1:0]        n_use,
    input  logic [$clog2(MAX_CONSTRAINTS+1)-1:0] k_use,
    input  logic                                 q_valid,
    input  q_item_t                              q_item,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output out_item_t                            out_data
);

    localparam int MD  = MAX_DIMS;
    localparam int MC  = MAX_CONSTRAINTS;
    localparam int DW  = $clog2(MD);
    localparam int LW  = $clog2((MD > MC) ? MD : MC);
    localparam int RW  = $clog2(MC + 1);
    localparam int EAW = $clog2(MC * MD);
    localparam int WAW = $clog2(MC * (MC + 1));
    localparam int UAW = (MC > 1) ? $clog2(MC) : 1;

    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_RD      = 22'h000002,
        S_MU      = 22'h000004,
        S_AC      = 22'h000008,
        S_FIN     = 22'h000010,
        S_PS_RD   = 22'h000020,
        S_PS_CMP  = 22'h000040,
        S_PS_DONE = 22'h000080,
        S_SW_RD   = 22'h000100,
        S_SW_W0   = 22'h000200,
        S_SW_W1   = 22'h000400,
        S_EF_RD   = 22'h000800,
        S_EF_DIV  = 22'h001000,
        S_EF_WAIT = 22'h002000,
        S_EU_RD   = 22'h004000,
        S_EU_MU   = 22'h008000,
        S_EU_WR   = 22'h010000,
        S_BS_RD   = 22'h020000,
        S_BS_DIV  = 22'h040000,
        S_BS_WAIT = 22'h080000,
        S_ORD     = 22'h100000,
        S_EMIT    = 22'h200000
    } state_t;

    typedef enum logic [3:0] {
        P_GRAM = 4'b0001,
        P_ZDOT = 4'b0010,
        P_BS   = 4'b0100,
        P_OUT  = 4'b1000
    } phase_t;

    function automatic logic [EAW-1:0] ea(input int r, input int cc);
        return EAW'(r * MD + cc);
    endfunction

    function automatic logic [WAW-1:0] wa(input int r, input int cc);
        return WAW'(r * (MC + 1) + cc);
    endfunction

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
        return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic logic [32:0] mag(input logic signed [31:0] v);
        logic signed [32:0] t;
        t = {v[31], v};
        return v[31] ? 33'(-t) : 33'(t);
    endfunction

    // memories
    logic signed [31:0] emem [0:MC*MD-1];
    logic signed [31:0] tmem [0:MC-1];
    logic signed [31:0] vmem [0:MD-1];
    logic signed [31:0] wmem [0:MC*(MC+1)-1];
    logic signed [31:0] umem [0:MC-1];

    logic [EAW-1:0] e_wa, e_ra0, e_ra1;
    logic [UAW-1:0] t_wa, t_ra, u_wa, u_ra;
    logic [DW-1:0]  v_wa, v_ra;
    logic [WAW-1:0] w_wa, w_ra0, w_ra1;
    logic           e_we, t_we, v_we, w_we, u_we;
    logic signed [31:0] w_wd;
    logic signed [31:0] e_rd0, e_rd1, t_rd, v_rd, w_rd0, w_rd1, u_rd;

    state_t          state_reg;
    phase_t          phase_reg;
    logic [RW-1:0]   i_reg, j_reg, p_reg, best_reg;
    logic [LW-1:0]   c_reg;
    logic [DW-1:0]   el_reg;
    logic            singular_reg;
    logic            out_valid_reg;
    out_item_t       out_data_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] hold_reg;
    logic signed [31:0] f_reg;
    logic signed [31:0] bestv_reg;

    logic signed [31:0] mul_a, mul_b;
    logic               div_start, div_done;
    logic signed [31:0] div_a, div_q;
    logic signed [31:0] emit_val;
    logic               slot_free;
    logic               emit_fire;
    int                 kl, nl, c_end;

    assign kl = int'(k_use) - 1;
    assign nl = int'(n_use) - 1;
    assign c_end = (phase_reg == P_GRAM || phase_reg == P_ZDOT) ? nl : kl;
    assign slot_free = !out_valid_reg || !out_stall;
    assign emit_fire = (state_reg == S_EMIT) && slot_free;

    // store loads from the queue
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign e_we  = q_pop && q_item.kind == K_MAT;
    assign t_we  = q_pop && q_item.kind == K_TGT;
    assign v_we  = q_pop && q_item.kind == K_VEC && q_item.wr;
    assign e_wa  = ea(int'(q_item.row), int'(q_item.col));
    assign t_wa  = UAW'(q_item.row);
    assign v_wa  = DW'(q_item.col);

    always_ff @(posedge clk)
    begin
        if (e_we)
            emem[e_wa] <= q_item.value;
        e_rd0 <= emem[e_ra0];
        e_rd1 <= emem[e_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
            tmem[t_wa] <= q_item.value;
        t_rd <= tmem[t_ra];
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            vmem[v_wa] <= q_item.value;
        v_rd <= vmem[v_ra];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            wmem[w_wa] <= w_wd;
        w_rd0 <= wmem[w_ra0];
        w_rd1 <= wmem[w_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (u_we)
            umem[u_wa] <= div_q;
        u_rd <= umem[u_ra];
    end

    // read addresses
    assign v_ra = (phase_reg == P_ZDOT) ? DW'(c_reg) : el_reg;
    assign t_ra = UAW'(i_reg);
    assign u_ra = UAW'(c_reg);

    always_comb
    begin
        e_ra0 = '0;
        e_ra1 = '0;
        w_ra0 = '0;
        w_ra1 = '0;
        case (state_reg)
            S_RD:
            begin
                case (phase_reg)
                    P_GRAM:
                    begin
                        e_ra0 = ea(int'(i_reg), int'(c_reg));
                        e_ra1 = ea(int'(j_reg), int'(c_reg));
                    end
                    P_ZDOT: e_ra0 = ea(int'(i_reg), int'(c_reg));
                    P_BS:   w_ra0 = wa(int'(i_reg), int'(c_reg));
                    P_OUT:  e_ra0 = ea(int'(c_reg), int'(el_reg));
                    default: e_ra0 = '0;
                endcase
            end
            S_PS_RD: w_ra0 = wa(int'(i_reg), int'(p_reg));
            S_SW_RD:
            begin
                w_ra0 = wa(int'(p_reg), int'(j_reg));
                w_ra1 = wa(int'(best_reg), int'(j_reg));
            end
            S_EF_RD:
            begin
                w_ra0 = wa(int'(i_reg), int'(p_reg));
                w_ra1 = wa(int'(p_reg), int'(p_reg));
            end
            S_EU_RD:
            begin
                w_ra0 = wa(int'(i_reg), int'(j_reg));
                w_ra1 = wa(int'(p_reg), int'(j_reg));
            end
            S_BS_RD:
            begin
                w_ra0 = wa(int'(i_reg), MC);
                w_ra1 = wa(int'(i_reg), int'(i_reg));
            end
            default: e_ra0 = '0;
        endcase
    end

    // work memory writes
    always_comb
    begin
        w_we = 1'b0;
        w_wa = '0;
        w_wd = '0;
        case (state_reg)
            S_FIN:
            begin
                if (phase_reg == P_GRAM)
                begin
                    w_we = 1'b1;
                    w_wa = wa(int'(i_reg), int'(j_reg));
                    w_wd = sat32(acc_reg);
                end
                else if (phase_reg == P_ZDOT)
                begin
                    w_we = 1'b1;
                    w_wa = wa(int'(i_reg), MC);
                    w_wd = sat32(acc_reg - sx64(t_rd));
                end
            end
            S_SW_W0:
            begin
                w_we = 1'b1;
                w_wa = wa(int'(p_reg), int'(j_reg));
                w_wd = w_rd1;
            end
            S_SW_W1:
            begin
                w_we = 1'b1;
                w_wa = wa(int'(best_reg), int'(j_reg));
                w_wd = hold_reg;
            end
            S_EU_WR:
            begin
                w_we = 1'b1;
                w_wa = wa(int'(i_reg), int'(j_reg));
                w_wd = sat32(sx64(hold_reg) - rnd(prod_reg));
            end
            default: w_we = 1'b0;
        endcase
    end

    assign u_we = (state_reg == S_BS_WAIT) && div_done;
    assign u_wa = UAW'(i_reg);

    // shared multiplier operands
    always_comb
    begin
        mul_a = e_rd0;
        mul_b = e_rd1;
        if (state_reg == S_EU_MU)
        begin
            mul_a = f_reg;
            mul_b = w_rd1;
        end
        else
        begin
            case (phase_reg)
                P_GRAM: mul_b = e_rd1;
                P_ZDOT: mul_b = v_rd;
                P_BS:
                begin
                    mul_a = w_rd0;
                    mul_b = u_rd;
                end
                P_OUT:  mul_b = u_rd;
                default: mul_b = e_rd1;
            endcase
        end
    end

    // divider shared by elimination and back substitution
    assign div_start = (state_reg == S_EF_DIV) || (state_reg == S_BS_DIV);
    assign div_a = (state_reg == S_EF_DIV) ? w_rd0 : sat32(sx64(w_rd0) - acc_reg);

    ecp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (w_rd1),
        .done  (div_done),
        .q     (div_q)
    );

    assign emit_val = singular_reg ? v_rd : sat32(sx64(v_rd) - acc_reg);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= P_GRAM;
            i_reg         <= '0;
            j_reg         <= '0;
            p_reg         <= '0;
            best_reg      <= '0;
            c_reg         <= '0;
            el_reg        <= '0;
            singular_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            acc_reg       <= '0;
            prod_reg      <= '0;
            hold_reg      <= '0;
            f_reg         <= '0;
            bestv_reg     <= '0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            // load a new item or drop the taken one
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && q_item.kind == K_VEC && q_item.last)
                    begin
                        phase_reg    <= P_GRAM;
                        singular_reg <= 1'b0;
                        i_reg        <= '0;
                        j_reg        <= '0;
                        c_reg        <= '0;
                        acc_reg      <= '0;
                        state_reg    <= S_RD;
                    end
                end
                S_RD: state_reg <= S_MU;
                S_MU: state_reg <= S_AC;
                S_AC:
                begin
                    acc_reg <= acc_reg + rnd(prod_reg);
                    if (int'(c_reg) == c_end)
                        state_reg <= S_FIN;
                    else
                    begin
                        c_reg     <= c_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_FIN:
                begin
                    case (phase_reg)
                        P_GRAM:
                        begin
                            acc_reg   <= '0;
                            c_reg     <= '0;
                            state_reg <= S_RD;
                            if (int'(j_reg) == kl)
                            begin
                                j_reg <= '0;
                                if (int'(i_reg) == kl)
                                begin
                                    i_reg     <= '0;
                                    phase_reg <= P_ZDOT;
                                end
                                else
                                    i_reg <= i_reg + 1'b1;
                            end
                            else
                                j_reg <= j_reg + 1'b1;
                        end
                        P_ZDOT:
                        begin
                            acc_reg <= '0;
                            c_reg   <= '0;
                            if (int'(i_reg) == kl)
                            begin
                                p_reg     <= '0;
                                i_reg     <= '0;
                                state_reg <= S_PS_RD;
                            end
                            else
                            begin
                                i_reg     <= i_reg + 1'b1;
                                state_reg <= S_RD;
                            end
                        end
                        P_BS: state_reg <= S_BS_RD;
                        P_OUT: state_reg <= S_EMIT;
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_PS_RD: state_reg <= S_PS_CMP;
                S_PS_CMP:
                begin
                    if (i_reg == p_reg || mag(w_rd0) > mag(bestv_reg))
                    begin
                        best_reg  <= i_reg;
                        bestv_reg <= w_rd0;
                    end
                    if (int'(i_reg) == kl)
                        state_reg <= S_PS_DONE;
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_PS_RD;
                    end
                end
                S_PS_DONE:
                begin
                    if (bestv_reg == '0)
                    begin
                        singular_reg <= 1'b1;
                        phase_reg    <= P_OUT;
                        el_reg       <= '0;
                        state_reg    <= S_ORD;
                    end
                    else if (best_reg != p_reg)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_SW_RD;
                    end
                    else if (int'(p_reg) == kl)
                    begin
                        phase_reg <= P_BS;
                        i_reg     <= RW'(kl);
                        acc_reg   <= '0;
                        state_reg <= S_BS_RD;
                    end
                    else
                    begin
                        i_reg     <= p_reg + 1'b1;
                        state_reg <= S_EF_RD;
                    end
                end
                S_SW_RD: state_reg <= S_SW_W0;
                S_SW_W0:
                begin
                    hold_reg  <= w_rd0;
                    state_reg <= S_SW_W1;
                end
                S_SW_W1:
                begin
                    if (int'(j_reg) == MC)
                    begin
                        if (int'(p_reg) == kl)
                        begin
                            phase_reg <= P_BS;
                            i_reg     <= RW'(kl);
                            acc_reg   <= '0;
                            state_reg <= S_BS_RD;
                        end
                        else
                        begin
                            i_reg     <= p_reg + 1'b1;
                            state_reg <= S_EF_RD;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_SW_RD;
                    end
                end
                S_EF_RD: state_reg <= S_EF_DIV;
                S_EF_DIV: state_reg <= S_EF_WAIT;
                S_EF_WAIT:
                begin
                    if (div_done)
                    begin
                        f_reg <= div_q;
                        if (int'(p_reg) + 1 <= kl)
                            j_reg <= p_reg + 1'b1;
                        else
                            j_reg <= RW'(MC);
                        state_reg <= S_EU_RD;
                    end
                end
                S_EU_RD: state_reg <= S_EU_MU;
                S_EU_MU:
                begin
                    hold_reg  <= w_rd0;
                    state_reg <= S_EU_WR;
                end
                S_EU_WR:
                begin
                    if (int'(j_reg) == MC)
                    begin
                        if (int'(i_reg) == kl)
                        begin
                            p_reg     <= p_reg + 1'b1;
                            i_reg     <= p_reg + 1'b1;
                            state_reg <= S_PS_RD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_EF_RD;
                        end
                    end
                    else if (int'(j_reg) == kl)
                    begin
                        j_reg     <= RW'(MC);
                        state_reg <= S_EU_RD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_EU_RD;
                    end
                end
                S_BS_RD: state_reg <= S_BS_DIV;
                S_BS_DIV: state_reg <= S_BS_WAIT;
                S_BS_WAIT:
                begin
                    if (div_done)
                    begin
                        acc_reg <= '0;
                        if (i_reg == '0)
                        begin
                            phase_reg <= P_OUT;
                            el_reg    <= '0;
                            c_reg     <= '0;
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            i_reg <= i_reg - 1'b1;
                            c_reg <= LW'(int'(i_reg));
                            if (int'(i_reg) - 1 == kl)
                                state_reg <= S_BS_RD;
                            else
                                state_reg <= S_RD;
                        end
                    end
                end
                S_ORD: state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_data_reg.index           <= 4'(el_reg);
                        out_data_reg.projected       <= emit_val;
                        out_data_reg.end_of_vector   <= (int'(el_reg) == nl);
                        out_data_reg.singular        <= singular_reg;
                        acc_reg <= '0;
                        c_reg   <= '0;
                        if (int'(el_reg) == nl)
                            state_reg <= S_IDLE;
                        else
                        begin
                            el_reg    <= el_reg + 1'b1;
                            state_reg <= singular_reg ? S_ORD : S_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hw/rtl/equality_constraint_projection.sv */
// ----------------------------------------------------------------------------
// equality_constraint_projection: projection of a vector onto E x = c
// Loads E and c entry by entry and projects each incoming vector.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid / in_stall / in_data) carries load items for E and
//   c and the elements of a vector; the element marked last starts the
//   projection. out channel (out_valid / out_stall / out_data) returns the
//   N projected elements in index order, the last one marked end_of_vector.
//   cfg_write / cfg_index / cfg_data set the vector length and row count;
//   write them only while the block is idle.
// Operation:
//   Load and element items pass through a four entry queue. A projection
//   forms E E^T and E x - c on one shared multiplier, each multiply-add
//   stepping through read, multiply and accumulate states, and uses one
//   shared divider for up to K*(K-1)/2 elimination factors and K back
//   substitutions. Items keep being queued while a projection runs until
//   the queue fills.
// Reset clears the control state; matrix, target and vector stores are
//   undefined until written. A stalled output holds its item and the
//   sequencer waits on it.
module equality_constraint_projection
    import ecp_pkg::*;
#(
    parameter int MAX_DIMS        = MAX_DIMS_DEF,
    parameter int MAX_CONSTRAINTS = MAX_CONSTRAINTS_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_write,
    input  logic      cfg_index,
    input  logic [4:0] cfg_data
);

    localparam int NW = $clog2(MAX_DIMS + 1);
    localparam int RW = $clog2(MAX_CONSTRAINTS + 1);

    logic [4:0]    dims_reg;
    logic [2:0]    cons_reg;
    logic [NW-1:0] n_use;
    logic [RW-1:0] k_use;
    logic          q_full, q_push, q_pop, q_valid;
    q_item_t       q_in, q_head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= 5'd16;
            cons_reg <= 3'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DIMS: dims_reg <= cfg_data;
                REG_CONS: cons_reg <= cfg_data[2:0];
                default:  dims_reg <= dims_reg;
            endcase
        end
    end

    // clamp sizes to the supported range
    always_comb
    begin
        if (dims_reg == '0)
            n_use = NW'(1);
        else if (int'(dims_reg) > MAX_DIMS)
            n_use = NW'(MAX_DIMS);
        else
            n_use = NW'(dims_reg);
        if (cons_reg == '0)
            k_use = RW'(1);
        else if (int'(cons_reg) > MAX_CONSTRAINTS)
            k_use = RW'(MAX_CONSTRAINTS);
        else
            k_use = RW'(cons_reg);
    end

    ecp_front #(
        .MAX_DIMS        (MAX_DIMS),
        .MAX_CONSTRAINTS (MAX_CONSTRAINTS)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    ecp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    ecp_back #(
        .MAX_DIMS        (MAX_DIMS),
        .MAX_CONSTRAINTS (MAX_CONSTRAINTS),
        .FRAC_BITS       (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .n_use     (n_use),
        .k_use     (k_use),
        .q_valid   (q_valid),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* hw/rtl/ecp_checker.sv */
// ----------------------------------------------------------------------------
// ecp_port_checks: port level checks for the projection block
// Handshake hold behavior and output ordering seen at the top level ports.
// ----------------------------------------------------------------------------
module ecp_port_checks
    import ecp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // hold a stalled input item
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled input item changed");

    // hold a stalled item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output item changed");

    // elements of one vector come in index order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.end_of_vector |=>
            !out_valid || out_data.index == $past(out_data.index) + 4'd1)
        else $error("output index skipped");

    // singular flag is the same over a vector
    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.end_of_vector |=>
            !out_valid || out_data.singular == $past(out_data.singular))
        else $error("singular flag changed within a vector");

    // a new vector starts at index zero
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.end_of_vector |=>
            !out_valid || out_data.index == 4'd0)
        else $error("vector did not start at index zero");

endmodule

bind equality_constraint_projection ecp_port_checks u_chk (.*);

/* sim/ecp_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecp_checker: projection predictor and result checker
// Mirrors E, c, the vector buffer and both registers from the accepted
// traffic. On each last element it computes the expected projected vector
// and compares every delivered item against the oldest expectation.
// ----------------------------------------------------------------------------
module ecp_checker
    import ecp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    input  logic      cfg_write,
    input  logic      cfg_index,
    input  logic [4:0] cfg_data,
    output int        failures,
    output int        pending
);

    longint    mat_e [4][16];
    longint    tgt_c [4];
    longint    vec_x [16];
    logic [4:0] dims_reg;
    logic [2:0] rows_reg;
    out_item_t projected_q [$];
    int        errs;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // round to nearest, ties up, kept wide
    function automatic longint qmul(longint a, longint b);
        return (a * b + 64'sd32768) >>> 16;
    endfunction

    // truncating divide, saturated
    function automatic longint qdiv(longint a, longint b);
        return clamp32((a * 64'sd65536) / b);
    endfunction

    // solve (E E^T) u = E x - c and queue x - E^T u
    task automatic predict_projection();
        longint    m [4][4];
        longint    z [4];
        longint    u [4];
        longint    acc, t, f, r;
        bit        sing;
        int        n, k, best;
        out_item_t e;
        n = (dims_reg < 1) ? 1 : (dims_reg > 16) ? 16 : int'(dims_reg);
        k = (rows_reg < 1) ? 1 : (rows_reg > 4) ? 4 : int'(rows_reg);
        sing = 0;
        for (int i = 0; i < k; i++)
        begin
            for (int j = 0; j < k; j++)
            begin
                acc = 0;
                for (int c = 0; c < n; c++)
                    acc += qmul(mat_e[i][c], mat_e[j][c]);
                m[i][j] = clamp32(acc);
            end
            acc = 0;
            for (int c = 0; c < n; c++)
                acc += qmul(mat_e[i][c], vec_x[c]);
            z[i] = clamp32(acc - tgt_c[i]);
        end
        // eliminate with partial pivoting, first row wins ties
        for (int p = 0; p < k && !sing; p++)
        begin
            best = p;
            for (int i = p + 1; i < k; i++)
                if ((m[i][p] < 0 ? -m[i][p] : m[i][p]) >
                    (m[best][p] < 0 ? -m[best][p] : m[best][p]))
                    best = i;
            if (m[best][p] == 0)
                sing = 1;
            else
            begin
                if (best != p)
                begin
                    for (int j = 0; j < k; j++)
                    begin
                        t = m[p][j]; m[p][j] = m[best][j]; m[best][j] = t;
                    end
                    t = z[p]; z[p] = z[best]; z[best] = t;
                end
                for (int i = p + 1; i < k; i++)
                begin
                    f = qdiv(m[i][p], m[p][p]);
                    for (int j = p + 1; j < k; j++)
                        m[i][j] = clamp32(m[i][j] - qmul(f, m[p][j]));
                    z[i] = clamp32(z[i] - qmul(f, z[p]));
                    m[i][p] = 0;
                end
            end
        end
        // back substitution
        if (!sing)
            for (int i = k - 1; i >= 0; i--)
            begin
                acc = z[i];
                for (int j = i + 1; j < k; j++)
                    acc -= qmul(m[i][j], u[j]);
                u[i] = qdiv(clamp32(acc), m[i][i]);
            end
        for (int j = 0; j < n; j++)
        begin
            r = vec_x[j];
            if (!sing)
            begin
                for (int i = 0; i < k; i++)
                    r -= qmul(mat_e[i][j], u[i]);
                r = clamp32(r);
            end
            e.index         = j[3:0];
            e.projected     = r[31:0];
            e.end_of_vector = (j == n - 1);
            e.singular      = sing;
            projected_q.push_back(e);
        end
    endtask

    // track state, predict and compare
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            dims_reg = 5'd16;
            rows_reg = 3'd1;
            projected_q.delete();
            errs = 0;
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_DIMS)
                    dims_reg = cfg_data;
                else
                    rows_reg = cfg_data[2:0];
            end
            if (out_valid && !out_stall)
            begin
                if (projected_q.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected item index %0d projected %0d",
                             $time, out_data.index, out_data.projected);
                end
                else
                begin
                    e = projected_q.pop_front();
                    if (out_data !== e)
                    begin
                        errs++;
                        $display("%0t: mismatch expected idx %0d val %0d eov %0b sing %0b",
                                 $time, e.index, e.projected, e.end_of_vector,
                                 e.singular);
                        $display("%0t:          actual   idx %0d val %0d eov %0b sing %0b",
                                 $time, out_data.index, out_data.projected,
                                 out_data.end_of_vector, out_data.singular);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                case (in_data.cmd)
                    CMD_LOAD_MAT: mat_e[in_data.row][in_data.col] = in_data.value;
                    CMD_LOAD_TGT: tgt_c[in_data.row] = in_data.value;
                    CMD_ELEMENT:
                    begin
                        vec_x[in_data.col] = in_data.value;
                        if (in_data.last)
                            predict_projection();
                    end
                    default: ;
                endcase
            end
            failures <= errs;
            pending  <= projected_q.size();
        end
    end

endmodule

/* sim/tb_equality_constraint_projection.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_equality_constraint_projection: testbench top
// Loads E and c, sends directed vectors (extremes, singular systems, ignored
// commands), then random vector traffic over several register settings with
// random gaps and stalls on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_equality_constraint_projection
    import ecp_pkg::*;
;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_write;
    logic      cfg_index;
    logic [4:0] cfg_data;
    int        failures;
    int        pending;
    int        cycles;
    bit        no_gaps;
    bit        hold_req;
    int        hold_left;
    int        burst_left;
    int        cur_dims;

    equality_constraint_projection u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ecp_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // abort on a hung run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver stalls: calm stretches, short bursts, rare long ones,
    // and one long hold-off on request
    initial
    begin
        out_stall  = 1'b0;
        hold_left  = 0;
        burst_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
                hold_left = 3000;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
                burst_left--;
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                    begin
                        out_stall <= 1'b0;
                        burst_left = $urandom_range(1, 30);
                    end
                    9:
                    begin
                        out_stall <= 1'b1;
                        burst_left = $urandom_range(10, 40);
                    end
                    default:
                    begin
                        out_stall <= 1'b1;
                        burst_left = $urandom_range(0, 3);
                    end
                endcase
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'h0001_0000;
                endcase
            end
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic in_item_t make_item(logic [1:0] cmd, int row, int col,
                                           logic [31:0] value, logic last);
        in_item_t it;
        it.cmd   = cmd;
        it.row   = row[1:0];
        it.col   = col[3:0];
        it.value = value;
        it.last  = last;
        return it;
    endfunction

    // offer one item, hold it until taken, then maybe go idle
    task automatic push_item(in_item_t it);
        int gap;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case ($urandom_range(0, 9))
            0, 1, 2: gap = $urandom_range(1, 3);
            3:       gap = $urandom_range(5, 30);
            default: gap = 0;
        endcase
        if (no_gaps)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // go quiet and wait until every projected item is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_regs(logic [4:0] dims, logic [4:0] rows);
        cfg_write <= 1'b1;
        cfg_index <= REG_DIMS;
        cfg_data  <= dims;
        @(posedge clk);
        cfg_index <= REG_CONS;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_dims = (dims < 1) ? 1 : (dims > 16) ? 16 : int'(dims);
    endtask

    task automatic send_vector(int n, logic [31:0] fill, bit use_fill);
        for (int j = 0; j < n; j++)
            push_item(make_item(CMD_ELEMENT, $urandom_range(0, 3), j,
                                use_fill ? fill : pick_value(), j == n - 1));
    endtask

    task automatic load_rows(int rows);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < 16; c++)
                push_item(make_item(CMD_LOAD_MAT, r, c, pick_value(),
                                    1'($urandom_range(0, 1))));
    endtask

    // mostly well-formed vectors with random content, some noise
    task automatic random_traffic(int budget);
        int sent;
        int cut;
        sent = 0;
        while (sent < budget)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    push_item(make_item(CMD_LOAD_MAT, $urandom_range(0, 3),
                                        $urandom_range(0, 15), pick_value(), 1'b0));
                    sent++;
                end
                1:
                begin
                    push_item(make_item(CMD_LOAD_TGT, $urandom_range(0, 3), 0,
                                        pick_value(), 1'($urandom_range(0, 1))));
                    push_item(make_item(CMD_UNUSED, $urandom_range(0, 3),
                                        $urandom_range(0, 15), $urandom, 1'b1));
                    sent += 2;
                end
                2:
                begin
                    // broken vector: a few random elements, early last
                    cut = $urandom_range(1, 4);
                    for (int j = 0; j < cut; j++)
                        push_item(make_item(CMD_ELEMENT, 0, $urandom_range(0, 15),
                                            pick_value(), j == cut - 1));
                    sent += cut;
                end
                default:
                begin
                    send_vector(cur_dims, 32'h0, 1'b0);
                    sent += cur_dims;
                end
            endcase
        end
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = REG_DIMS;
        cfg_data  = '0;
        no_gaps   = 1'b0;
        hold_req  = 1'b0;
        cur_dims  = 16;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every store once, then an extreme vector at reset settings
        load_rows(4);
        for (int r = 0; r < 4; r++)
            push_item(make_item(CMD_LOAD_TGT, r, 15, pick_value(), 1'b0));
        for (int j = 0; j < 15; j++)
            push_item(make_item(CMD_ELEMENT, 0, j, pick_value(), 1'b0));
        push_item(make_item(CMD_UNUSED, 3, 15, 32'hFFFF_FFFF, 1'b1));
        push_item(make_item(CMD_ELEMENT, 0, 15, 32'h8000_0000, 1'b1));
        send_vector(16, 32'h7FFF_FFFF, 1'b1);
        drain();

        // dependent rows give a zero pivot
        write_regs(5'd2, 5'd2);
        push_item(make_item(CMD_LOAD_MAT, 0, 0, 32'h0001_0000, 1'b0));
        push_item(make_item(CMD_LOAD_MAT, 1, 0, 32'h0001_0000, 1'b0));
        push_item(make_item(CMD_LOAD_MAT, 0, 1, 32'h0002_0000, 1'b0));
        push_item(make_item(CMD_LOAD_MAT, 1, 1, 32'h0002_0000, 1'b0));
        send_vector(2, 32'h0, 1'b0);
        drain();
        // all-zero row gives a zero pivot
        write_regs(5'd2, 5'd1);
        push_item(make_item(CMD_LOAD_MAT, 0, 0, 32'h0, 1'b0));
        push_item(make_item(CMD_LOAD_MAT, 0, 1, 32'h0, 1'b0));
        send_vector(2, 32'h0, 1'b0);
        drain();

        // random phases; the first one runs with a long receiver hold-off
        write_regs(5'd16, 5'd4);
        hold_req = 1'b1;
        send_vector(16, 32'h0, 1'b0);
        hold_req = 1'b0;
        random_traffic(6);
        write_regs(5'd1, 5'd1);
        no_gaps = 1'b1;
        random_traffic(4);
        no_gaps = 1'b0;
        write_regs(5'd0, 5'd0);
        random_traffic(3);
        write_regs(5'd31, 5'd7);
        random_traffic(8);
        write_regs(5'd5, 5'd3);
        random_traffic(5);
        write_regs(5'($urandom_range(1, 16)), 5'($urandom_range(1, 4)));
        random_traffic(6);
        repeat (50) @(posedge clk);

        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
